FILE: design/sac_pkg.sv
// Shared constants and command codes for the set-associative cache tag directory.
package sac_pkg;

   // Default geometry
   localparam int DEF_NUM_SETS    = 16;
   localparam int DEF_WAYS        = 4;
   localparam int DEF_BLOCK_BYTES = 64;

   // Field widths
   localparam int ADDR_W    = 32;
   localparam int STAMP_W   = 32;
   localparam int RRPV_W    = 2;
   localparam int CMD_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Commands
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FILL    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd3;

   // Replacement policies
   localparam logic POLICY_LRU   = 1'b0;
   localparam logic POLICY_SRRIP = 1'b1;

   // Re-reference prediction values
   localparam logic [RRPV_W-1:0] RRPV_MAX    = 2'd3;
   localparam logic [RRPV_W-1:0] RRPV_INSERT = RRPV_MAX - 2'd1;
   localparam logic [RRPV_W-1:0] RRPV_NEAR   = 2'd0;

endpackage

FILE: design/set_assoc_cache_lru_srrip.sv
// Tag directory of a write-back set-associative cache with LRU or SRRIP replacement.
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   tdata: command, address
//   rsp      out  rsp_tvalid/rsp_tready   tdata: hit, way, writeback, victim_address,
//                                                line_missing
//   csr      in   csr_valid/csr_ready     csr_data: replacement_policy
//
// One set row (all ways) is read from a single RAM, updated and written back.
// An item is accepted and its row read from RAM, then the row is updated and the
// result registered. An LRU fill into a full set adds an oldest-stamp scan.
// After reset a clearing pass zeroes every row; no item is taken meanwhile. A
// stalled result holds the item in the update cycle.
module set_assoc_cache_lru_srrip
   import sac_pkg::*;
#(
   parameter int NUM_SETS    = DEF_NUM_SETS,
   parameter int WAYS        = DEF_WAYS,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   // command [1:0], address [33:2], zero [39:34]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hit [0], way [2:1], writeback [3], victim_address [35:4], line_missing [36],
   // zero [39:37]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_data,
   input  logic                  csr_valid,
   output logic                  csr_ready
);

   localparam int OFF_BITS = $clog2(BLOCK_BYTES);
   localparam int SET_BITS = $clog2(NUM_SETS);
   localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int V_LO     = 0;
   localparam int D_LO     = WAYS;
   localparam int T_LO     = 2 * WAYS;
   localparam int S_LO     = T_LO + WAYS * TAG_W;
   localparam int R_LO     = S_LO + WAYS * STAMP_W;
   localparam int ROW_W    = R_LO + WAYS * RRPV_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_SCAN  = 2'd3;

   // Control and item registers
   logic [1:0]         state_ff, state_in;
   logic [SET_W-1:0]   clr_idx_ff, clr_idx_in;
   logic               policy_ff, policy_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [WAY_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [WAY_W-1:0]   best_way_ff, best_way_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [1:0]         rsp_way_ff, rsp_way_in;
   logic               rsp_wb_ff, rsp_wb_in;
   logic [ADDR_W-1:0]  rsp_victim_ff, rsp_victim_in;
   logic               rsp_missing_ff, rsp_missing_in;

   // Request decode
   logic [CMD_W-1:0]  req_cmd;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] req_block;
   logic [SET_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;
   logic              req_xfer;

   // RAM ports
   logic             ram_we;
   logic [SET_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] ram_q;

   // Row fields as read and as written back
   logic [WAYS-1:0]                 q_v, q_d, n_v, n_d;
   logic [WAYS-1:0][TAG_W-1:0]      q_tag, n_tag;
   logic [WAYS-1:0][STAMP_W-1:0]    q_stamp, n_stamp;
   logic [WAYS-1:0][RRPV_W-1:0]     q_rr, n_rr, aged_rr;

   // Way selection
   logic             hit, full, is_fill, need_scan, out_free, work_done, finish;
   logic [WAY_W-1:0] hit_way, inv_way, rr_way, scan_cand, victim_way, res_way;
   logic [RRPV_W-1:0] rr_top, rr_lift;
   logic             any3, any2, any1;
   logic             res_wb;

   assign req_cmd   = req_tdata[CMD_W-1:0];
   assign req_addr  = req_tdata[CMD_W +: ADDR_W];
   assign req_block = req_addr >> OFF_BITS;
   assign req_set   = SET_W'(req_block & ADDR_W'(NUM_SETS - 1));
   assign req_tag   = TAG_W'(req_block >> SET_BITS);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Set directory storage: one row per set
   sac_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_xfer),
      .rd_addr (req_set),
      .rd_data (ram_q)
   );

   // Unpack the row
   assign q_v     = ram_q[V_LO +: WAYS];
   assign q_d     = ram_q[D_LO +: WAYS];
   assign q_tag   = ram_q[T_LO +: WAYS * TAG_W];
   assign q_stamp = ram_q[S_LO +: WAYS * STAMP_W];
   assign q_rr    = ram_q[R_LO +: WAYS * RRPV_W];

   // Search the set: lowest hit way, lowest free way, SRRIP aging
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      inv_way = '0;
      rr_way  = '0;
      any3    = 1'b0;
      any2    = 1'b0;
      any1    = 1'b0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (q_v[w] && (q_tag[w] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!q_v[w]) begin
            inv_way = WAY_W'(w);
         end
         any3 = any3 | (q_rr[w] == 2'd3);
         any2 = any2 | (q_rr[w] == 2'd2);
         any1 = any1 | (q_rr[w] == 2'd1);
      end
      full = &q_v;
      if (any3) begin
         rr_top = 2'd3;
      end else if (any2) begin
         rr_top = 2'd2;
      end else if (any1) begin
         rr_top = 2'd1;
      end else begin
         rr_top = 2'd0;
      end
      rr_lift = RRPV_MAX - rr_top;
      for (int w = WAYS - 1; w >= 0; w--) begin
         aged_rr[w] = q_rr[w] + rr_lift;
         if (aged_rr[w] == RRPV_MAX) begin
            rr_way = WAY_W'(w);
         end
      end
   end

   // One step of the oldest-stamp scan; strict compare keeps the lower way on ties
   assign scan_cand = (q_stamp[scan_idx_ff] < best_stamp_ff) ? scan_idx_ff : best_way_ff;

   assign is_fill   = (cmd_ff == CMD_FILL);
   assign need_scan = is_fill && full && (policy_ff == POLICY_LRU) && (WAYS > 1);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign work_done = ((state_ff == ST_LOOK) && !need_scan) ||
                      ((state_ff == ST_SCAN) && (scan_idx_ff == WAY_W'(WAYS - 1)));
   assign finish    = work_done && out_free;

   // Victim for a fill
   always_comb begin
      if (!full) begin
         victim_way = inv_way;
      end else if (policy_ff == POLICY_SRRIP) begin
         victim_way = rr_way;
      end else if (state_ff == ST_SCAN) begin
         victim_way = scan_cand;
      end else begin
         victim_way = '0;
      end
   end

   // Build the updated row
   always_comb begin
      n_v     = q_v;
      n_d     = q_d;
      n_tag   = q_tag;
      n_stamp = q_stamp;
      n_rr    = (is_fill && full && (policy_ff == POLICY_SRRIP)) ? aged_rr : q_rr;
      if (is_fill) begin
         n_v[victim_way]   = 1'b1;
         n_d[victim_way]   = 1'b0;
         n_tag[victim_way] = tag_ff;
         if (policy_ff == POLICY_SRRIP) begin
            n_rr[victim_way] = RRPV_INSERT;
         end else begin
            n_stamp[victim_way] = counter_ff;
         end
      end else if (hit) begin
         if (policy_ff == POLICY_SRRIP) begin
            n_rr[hit_way] = RRPV_NEAR;
         end else begin
            n_stamp[hit_way] = counter_ff;
         end
         if ((cmd_ff == CMD_WRITE) || (cmd_ff == CMD_REPLACE)) begin
            n_d[hit_way] = 1'b1;
         end
      end
   end

   assign res_way = is_fill ? victim_way : (hit ? hit_way : '0);
   assign res_wb  = is_fill && full && q_d[victim_way];

   // Write back the row, or zero it during the clearing pass
   assign ram_we    = (state_ff == ST_CLEAR) || finish;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_idx_ff : set_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : {n_rr, n_stamp, n_tag, n_d, n_v};

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      policy_in     = policy_ff;
      counter_in    = counter_ff;
      cmd_in        = cmd_ff;
      tag_in        = tag_ff;
      set_in        = set_ff;
      scan_idx_in   = scan_idx_ff;
      best_way_in   = best_way_ff;
      best_stamp_in = best_stamp_ff;

      if (csr_valid && csr_ready) begin
         policy_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + SET_W'(1);
            if (clr_idx_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in   = ST_LOOK;
               counter_in = counter_ff + STAMP_W'(1);
               cmd_in     = req_cmd;
               tag_in     = req_tag;
               set_in     = req_set;
            end
         end
         ST_LOOK: begin
            if (need_scan) begin
               state_in      = ST_SCAN;
               scan_idx_in   = WAY_W'(1);
               best_way_in   = '0;
               best_stamp_in = q_stamp[0];
            end else if (finish) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            best_way_in   = scan_cand;
            best_stamp_in = q_stamp[scan_cand];
            if (scan_idx_ff != WAY_W'(WAYS - 1)) begin
               scan_idx_in = scan_idx_ff + WAY_W'(1);
            end
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Result register: load on finish, drop on transfer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_way_in     = rsp_way_ff;
      rsp_wb_in      = rsp_wb_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_missing_in = rsp_missing_ff;
      if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = hit;
         rsp_way_in     = 2'(res_way);
         rsp_wb_in      = res_wb;
         rsp_victim_in  = res_wb ? ((ADDR_W'(q_tag[victim_way]) << (OFF_BITS + SET_BITS)) |
                                    (ADDR_W'(set_ff) << OFF_BITS)) : '0;
         rsp_missing_in = (cmd_ff == CMD_REPLACE) && !hit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         policy_ff    <= POLICY_LRU;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         policy_ff    <= policy_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      tag_ff         <= tag_in;
      set_ff         <= set_in;
      scan_idx_ff    <= scan_idx_in;
      best_way_ff    <= best_way_in;
      best_stamp_ff  <= best_stamp_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_way_ff     <= rsp_way_in;
      rsp_wb_ff      <= rsp_wb_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_missing_ff <= rsp_missing_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_missing_ff, rsp_victim_ff, rsp_wb_ff, rsp_way_ff, rsp_hit_ff};

`ifndef SYNTH
   // An accepted item moves on to the row update
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_LOOK))
      else $error("accepted item did not advance to row update");

   // The RAM is written only by the clearing pass or a finishing item
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_LOOK) || (state_ff == ST_SCAN)))
      else $error("directory written outside clear or update");

   // A new result appears only after an update cycle
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> ((state_ff == ST_LOOK) || (state_ff == ST_SCAN)))
      else $error("result raised outside update");

   // A missing line is never a hit
   a_missing_not_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_missing_ff) |-> !rsp_hit_ff)
      else $error("line_missing reported together with hit");

   // A victim address is given only with a writeback
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_wb_ff) |-> (rsp_victim_ff == '0))
      else $error("victim address without writeback");
`endif

endmodule

FILE: design/sac_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last word while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/sv/sac_dir_checker.sv
// Checker for the cache tag directory: tracks the set contents, predicts each result and compares.
`timescale 1ns / 1ps
module sac_dir_checker
   import sac_pkg::*;
(
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [REQ_DATA_W-1:0]                      req_tdata,
   input  logic                                       req_tvalid,
   input  logic                                       req_tready,
   input  logic [RSP_DATA_W-1:0]                      rsp_tdata,
   input  logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic                                       csr_data,
   input  logic                                       csr_valid,
   input  logic                                       csr_ready,
   output int                                         failures,
   output int                                         outstanding,
   output int                                         dirty_evictions,
   output logic [DEF_NUM_SETS*DEF_WAYS-1:0]           resident_mask,
   output logic [DEF_NUM_SETS*DEF_WAYS-1:0][ADDR_W-1:0] resident_addr
);

   localparam int WAYS  = DEF_WAYS;
   localparam int OFF_W = $clog2(DEF_BLOCK_BYTES);
   localparam int SET_W = $clog2(DEF_NUM_SETS);
   localparam int TAG_W = ADDR_W - OFF_W - SET_W;
   localparam int LINES = DEF_NUM_SETS * WAYS;

   typedef struct packed {
      logic              hit;
      logic [1:0]        way;
      logic              writeback;
      logic [ADDR_W-1:0] victim;
      logic              missing;
   } dir_result_type;

   // Shadow directory
   logic [LINES-1:0]   line_vld;
   logic [LINES-1:0]   line_drt;
   logic [TAG_W-1:0]   line_tag   [LINES];
   logic [STAMP_W-1:0] line_stamp [LINES];
   logic [RRPV_W-1:0]  line_rrpv  [LINES];
   logic [STAMP_W-1:0] access_cnt;
   logic               policy;

   dir_result_type pending_results [$];

   initial begin
      failures        = 0;
      outstanding     = 0;
      dirty_evictions = 0;
   end

   // Apply one command to the shadow directory and return the result it yields
   function automatic dir_result_type access_directory(input logic [CMD_W-1:0]  op,
                                                       input logic [ADDR_W-1:0] a);
      dir_result_type     r;
      logic [SET_W-1:0]   s;
      logic [TAG_W-1:0]   t;
      logic [RRPV_W-1:0]  peak;
      logic [STAMP_W-1:0] oldest;
      int                 base;
      int                 w;
      int                 pick;
      r    = '0;
      s    = a[OFF_W +: SET_W];
      t    = a[ADDR_W-1 -: TAG_W];
      base = int'(s) * WAYS;
      access_cnt = access_cnt + 1'b1;
      // search from the top so the lowest matching way wins
      for (w = WAYS - 1; w >= 0; w--) begin
         if (line_vld[base + w] && line_tag[base + w] == t) begin
            r.hit = 1'b1;
            r.way = w[1:0];
         end
      end
      if (op == CMD_FILL) begin
         pick = -1;
         for (w = WAYS - 1; w >= 0; w--) begin
            if (!line_vld[base + w]) pick = w;
         end
         // full set: pick a victim by the active policy
         if (pick < 0) begin
            if (policy == POLICY_LRU) begin
               pick   = 0;
               oldest = line_stamp[base];
               for (w = 1; w < WAYS; w++) begin
                  if (line_stamp[base + w] < oldest) begin
                     oldest = line_stamp[base + w];
                     pick   = w;
                  end
               end
            end else begin
               peak = '0;
               for (w = 0; w < WAYS; w++) begin
                  if (line_rrpv[base + w] > peak) peak = line_rrpv[base + w];
               end
               for (w = 0; w < WAYS; w++) begin
                  line_rrpv[base + w] = line_rrpv[base + w] + (RRPV_MAX - peak);
               end
               pick = 0;
               for (w = WAYS - 1; w >= 0; w--) begin
                  if (line_rrpv[base + w] == RRPV_MAX) pick = w;
               end
            end
            if (line_drt[base + pick]) begin
               r.writeback = 1'b1;
               r.victim    = {line_tag[base + pick], s, {OFF_W{1'b0}}};
               dirty_evictions++;
            end
         end
         r.way                = pick[1:0];
         line_vld[base + pick] = 1'b1;
         line_drt[base + pick] = 1'b0;
         line_tag[base + pick] = t;
         if (policy == POLICY_LRU) line_stamp[base + pick] = access_cnt;
         else line_rrpv[base + pick] = RRPV_INSERT;
      end else if (r.hit) begin
         // promote the hit line, mark it dirty on writes
         if (policy == POLICY_LRU) line_stamp[base + r.way] = access_cnt;
         else line_rrpv[base + r.way] = RRPV_NEAR;
         if (op == CMD_WRITE || op == CMD_REPLACE) line_drt[base + r.way] = 1'b1;
      end else if (op == CMD_REPLACE) begin
         r.missing = 1'b1;
      end
      return r;
   endfunction

   task automatic report_fault(input string msg);
      failures++;
      if (failures <= 10) $display("%t: %s", $realtime, msg);
   endtask

   // Watch all three channels; results first, then config, then new requests
   always @(posedge clock) begin : watch
      dir_result_type got;
      dir_result_type want;
      string          bad;
      if (reset) begin
         line_vld   = '0;
         line_drt   = '0;
         access_cnt = '0;
         policy     = POLICY_LRU;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit       = rsp_tdata[0];
            got.way       = rsp_tdata[2:1];
            got.writeback = rsp_tdata[3];
            got.victim    = rsp_tdata[35:4];
            got.missing   = rsp_tdata[36];
            if (pending_results.size() == 0) begin
               report_fault($sformatf("result transfer with nothing outstanding: %p", got));
            end else begin
               want = pending_results.pop_front();
               bad  = "";
               if (got.hit !== want.hit) bad = {bad, " hit"};
               if (got.way !== want.way) bad = {bad, " way"};
               if (got.writeback !== want.writeback) bad = {bad, " writeback"};
               if (got.victim !== want.victim) bad = {bad, " victim_address"};
               if (got.missing !== want.missing) bad = {bad, " line_missing"};
               if (bad != "") begin
                  report_fault({$sformatf("mismatch on%s: expected hit=%0d way=%0d wb=%0d ",
                                          bad, want.hit, want.way, want.writeback),
                                $sformatf("victim=%h missing=%0d, got hit=%0d way=%0d wb=%0d ",
                                          want.victim, want.missing, got.hit, got.way,
                                          got.writeback),
                                $sformatf("victim=%h missing=%0d", got.victim, got.missing)});
               end
            end
         end
         if (csr_valid && csr_ready) policy = csr_data;
         if (req_tvalid && req_tready) begin
            pending_results.push_back(access_directory(req_tdata[CMD_W-1:0],
                                                       req_tdata[CMD_W +: ADDR_W]));
         end
      end
      outstanding <= pending_results.size();
   end

   // Expose resident lines so the stimulus can revisit them
   for (genvar i = 0; i < LINES; i++) begin : g_resident
      localparam logic [SET_W-1:0] SET_OF = SET_W'(i / WAYS);
      assign resident_mask[i] = line_vld[i];
      assign resident_addr[i] = {line_tag[i], SET_OF, {OFF_W{1'b0}}};
   end

endmodule

FILE: tb/sv/tb_set_assoc_cache_lru_srrip.sv
// Testbench top for the cache tag directory: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_srrip;
   import sac_pkg::*;

   localparam int    OFF_W        = $clog2(DEF_BLOCK_BYTES);
   localparam int    SET_W        = $clog2(DEF_NUM_SETS);
   localparam int    TAG_W        = ADDR_W - OFF_W - SET_W;
   localparam int    LINES        = DEF_NUM_SETS * DEF_WAYS;
   localparam int    DRAIN_CYCLES = 2 + DEF_WAYS + 2;
   localparam longint TIMEOUT_NS  = 64'd4_800_000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_data   = POLICY_LRU;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;

   int                        failures;
   int                        outstanding;
   int                        dirty_evictions;
   logic [LINES-1:0]             resident_mask;
   logic [LINES-1:0][ADDR_W-1:0] resident_addr;

   logic             stall_enable = 1'b1;
   int               sent         = 0;
   int               phases       = 0;
   logic [TAG_W-1:0] tag_pool [6];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   set_assoc_cache_lru_srrip dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   sac_dir_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_data        (csr_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .failures        (failures),
      .outstanding     (outstanding),
      .dirty_evictions (dirty_evictions),
      .resident_mask   (resident_mask),
      .resident_addr   (resident_addr)
   );

   // Stall the result channel in random bursts
   always begin
      @(posedge clock);
      if (stall_enable && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   function automatic logic [ADDR_W-1:0] line_addr(input int t, input int s,
                                                   input int o);
      return {t[TAG_W-1:0], s[SET_W-1:0], o[OFF_W-1:0]};
   endfunction

   // True when the block holding this address is resident in its set
   function automatic logic is_resident(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] blk;
      blk = {a[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
      for (int i = 0; i < LINES; i++) begin
         if (resident_mask[i] && resident_addr[i] == blk) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Send one request; returns at the edge of its transfer with valid still high
   task automatic push_request(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] a);
      if (stall_enable && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - CMD_W - ADDR_W){1'b0}}, a, op};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Switch policy while idle, then touch every resident line under the new policy
   task automatic write_policy(input logic p);
      drain_results();
      csr_data  <= p;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      phases++;
      for (int i = 0; i < LINES; i++) begin
         if (resident_mask[i]) begin
            push_request(CMD_LOOKUP,
                         resident_addr[i] | ADDR_W'($urandom_range(0, DEF_BLOCK_BYTES - 1)));
         end
      end
   endtask

   // Random traffic over a small tag pool so sets fill, hit and evict
   task automatic random_phase(input int n);
      logic [CMD_W-1:0]  op;
      logic [ADDR_W-1:0] a;
      int                pct;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int k = 2; k < 6; k++) tag_pool[k] = TAG_W'($urandom);
      for (int i = 0; i < n; i++) begin
         // step past the last transfer edge; the block is busy there anyway
         @(posedge clock);
         pct = $urandom_range(0, 99);
         if (pct < 25) op = CMD_LOOKUP;
         else if (pct < 45) op = CMD_WRITE;
         else if (pct < 80) op = CMD_FILL;
         else op = CMD_REPLACE;
         if ($urandom_range(0, 9) == 0) a = $urandom;
         else a = line_addr(tag_pool[$urandom_range(0, 5)], $urandom_range(0, DEF_NUM_SETS - 1),
                            $urandom_range(0, DEF_BLOCK_BYTES - 1));
         // never refill a resident block, so no set holds a tag twice
         if (op == CMD_FILL && is_resident(a)) op = CMD_LOOKUP;
         if (i == n / 2) drain_results();
         push_request(op, a);
      end
   endtask

   // Main sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_policy(POLICY_LRU);

      // misses on an empty directory
      push_request(CMD_LOOKUP, line_addr(0, 0, 0));
      push_request(CMD_WRITE, line_addr(0, 0, 0));
      push_request(CMD_REPLACE, 32'hFFFF_FFFF);
      // fills into free ways, duplicate fill of the same block
      push_request(CMD_FILL, line_addr(0, 0, 0));
      push_request(CMD_FILL, line_addr(0, 0, DEF_BLOCK_BYTES - 1));
      push_request(CMD_LOOKUP, line_addr(0, 0, 5));
      push_request(CMD_REPLACE, line_addr(0, 0, 0));
      push_request(CMD_FILL, 32'hFFFF_FFFF);
      push_request(CMD_WRITE, 32'hFFFF_FFC0);
      // fill set 0, then evict by oldest stamp (clean, then dirty)
      push_request(CMD_FILL, line_addr(1, 0, 0));
      push_request(CMD_FILL, line_addr(2, 0, 0));
      push_request(CMD_FILL, line_addr(3, 0, 0));
      push_request(CMD_FILL, line_addr(4, 0, 0));
      push_request(CMD_WRITE, line_addr(2, 0, 0));

      write_policy(POLICY_SRRIP);
      // aging on a full set, promotion and dirty victims
      push_request(CMD_FILL, line_addr(5, 0, 0));
      push_request(CMD_FILL, line_addr(6, 0, 0));
      push_request(CMD_LOOKUP, line_addr(5, 0, 0));
      push_request(CMD_REPLACE, line_addr(6, 0, 0));
      push_request(CMD_FILL, line_addr(7, 0, 0));
      push_request(CMD_FILL, line_addr(8, 0, 0));
      push_request(CMD_FILL, line_addr(9, 0, 0));
      push_request(CMD_FILL, line_addr(10, 0, 0));
      push_request(CMD_REPLACE, line_addr('1, 5, 0));
      push_request(CMD_FILL, 32'hFFFF_FBFF);

      random_phase(330);
      write_policy(POLICY_LRU);
      random_phase(330);
      write_policy(POLICY_SRRIP);
      random_phase(330);
      write_policy(POLICY_LRU);
      random_phase(330);
      write_policy(POLICY_SRRIP);
      stall_enable = 1'b0;
      random_phase(280);

      // wait out the tail, bounded
      req_tvalid <= 1'b0;
      for (int k = 0; k < 20000 && (k == 0 || outstanding != 0); k++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over %0d policy phases (LRU and SRRIP), %0d dirty evictions",
               sent, phases, dirty_evictions);
      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      if (failures == 0 && outstanding == 0) begin
         $display("tb_set_assoc_cache_lru_srrip: done, clean");
      end else begin
         $display("tb_set_assoc_cache_lru_srrip: done, errors");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #(TIMEOUT_NS);
      $display("tb_set_assoc_cache_lru_srrip: done, errors");
      $finish;
   end

endmodule

FILE: set_assoc_cache_lru_srrip.f
design/sac_pkg.sv
design/sac_ram.sv
design/set_assoc_cache_lru_srrip.sv
tb/sv/sac_dir_checker.sv
tb/sv/tb_set_assoc_cache_lru_srrip.sv
